[hdl/kronecker_eigen_spectrum_assert.svh]
// Assertion macros used by the port checker file.
`ifndef KRONECKER_EIGEN_SPECTRUM_ASSERT_SVH
`define KRONECKER_EIGEN_SPECTRUM_ASSERT_SVH
`define KES_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define KES_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[hdl/kes_pkg.sv]
// Package with types and constants of the Kronecker eigenvalue spectrum block.
`default_nettype none
package kes_pkg;
    localparam int KES_MAX_ORDER = 31;
    localparam int KES_FRAC_BITS = 30;

    typedef struct packed {
        logic signed [31:0] eig_large;
        logic signed [31:0] eig_small;
        logic [4:0]         power_order;
    } kes_req_t;

    typedef struct packed {
        logic signed [62:0] eig_value;
        logic [28:0]        multiplicity;
        logic [4:0]         rank_index;
        logic               last_pair;
    } kes_res_t;

    typedef struct packed {
        logic start;
        logic neg;
    } kes_mul_ctl_t;
endpackage
`default_nettype wire

[hdl/kes_mul.sv]
// Sequential fixed-point multiplier: floor of a*e over 2^FRAC_BITS with saturation.
`default_nettype none
module kes_mul
    import kes_pkg::*;
#(
    parameter int FRAC_BITS = KES_FRAC_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kes_mul_ctl_t       ctl,
    input  wire logic [62:0]        mag_v,
    input  wire logic [31:0]        mag_e,
    output logic                    done,
    output logic signed [62:0]      prod
);
    localparam logic [63:0] VAL_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAL_NEG = 64'h4000_0000_0000_0000;

    logic [94:0] acc_reg, acc_next;
    logic [62:0] mv_reg, mv_next;
    logic [31:0] me_reg, me_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [94:0] part;
    logic [94:0] quot;
    logic        rem_nz;
    logic [95:0] qr;
    logic [63:0] lim;
    logic [63:0] mag;

    always_comb
    begin
        acc_next  = acc_reg;
        mv_next   = mv_reg;
        me_next   = me_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        part      = 95'(me_reg[cnt_reg[4:0]] ? mv_reg : 63'd0) << cnt_reg[4:0];
        if (ctl.start)
        begin
            acc_next  = '0;
            mv_next   = mag_v;
            me_next   = mag_e;
            neg_next  = ctl.neg;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + part;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mv_reg  <= mv_next;
        me_reg  <= me_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        quot   = acc_reg >> FRAC_BITS;
        rem_nz = |(acc_reg & ((95'd1 << FRAC_BITS) - 95'd1));
        qr     = {1'b0, quot} + 96'((neg_reg && rem_nz) ? 1 : 0);
        lim    = neg_reg ? VAL_NEG : VAL_MAX;
        mag    = (qr > 96'(lim)) ? lim : qr[63:0];
        prod   = neg_reg ? 63'(64'd0 - mag) : mag[62:0];
    end

    assign done = done_reg;
endmodule
`default_nettype wire

[hdl/kronecker_eigen_spectrum.sv]
// Top level of the Kronecker power eigenvalue spectrum block.
// Usage: drive req and raise start while busy is low; the item is taken at that edge.
// The block then builds the N+1 values eig_large^(N-i)*eig_small^i by repeated multiplication
// on one shift-add multiplier (N multiplies per value), forms the binomial
// multiplicities C(N,i) with a bit-serial divider, and sorts the pairs with an
// exchange sort, each compare-swap passing a read state and a compare state.
// Results then come out one per cycle on res, marked by res_valid, the last
// one with last_pair set; busy drops in the cycle that shows the final result,
// and the next item may be taken at the edge that ends that cycle.
// One item is in the block at a time; busy stays high until it is done.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears the sequencer and returns the block to idle; the value and
// multiplicity memories hold no reset and are written before every read.
`default_nettype none
module kronecker_eigen_spectrum
    import kes_pkg::*;
#(
    parameter int MAX_ORDER = KES_MAX_ORDER,
    parameter int FRAC_BITS = KES_FRAC_BITS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire kes_req_t req,
    output logic          busy,
    output logic          res_valid,
    output kes_res_t      res
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SRD   = 3'd4;
    localparam logic [2:0] S_SCMP  = 3'd5;
    localparam logic [2:0] S_ERD   = 3'd6;
    localparam logic [2:0] S_EOUT  = 3'd7;

    logic signed [62:0] value_mem [32];
    logic [28:0]        mult_mem [32];

    logic [2:0]  state_reg, state_next;
    logic [4:0]  n_reg, n_next;
    logic signed [31:0] big_reg, big_next, sml_reg, sml_next;
    logic [5:0]  i_reg, i_next;
    logic [5:0]  k_reg, k_next;
    logic signed [62:0] v_reg, v_next;
    logic [33:0] binom_reg, binom_next;
    logic [33:0] rem_reg, rem_next;
    logic [5:0]  dcnt_reg, dcnt_next;
    logic [4:0]  p_reg, p_next;
    logic [4:0]  q_reg, q_next;
    logic signed [62:0] vp_reg, vq_reg;
    logic [28:0] mp_reg, mq_reg;
    logic        rv_reg, rv_next;
    kes_res_t    res_reg, res_next;

    kes_mul_ctl_t       mctl;
    logic               mdone;
    logic signed [62:0] mprod;
    logic signed [31:0] mul_e;
    logic [4:0]  n_clip;
    logic [33:0] dtrial;
    logic        wr_en;
    logic [4:0]  wr_addr;
    logic        swap;

    kes_mul #(.FRAC_BITS(FRAC_BITS)) u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .mag_v (v_reg[62] ? 63'(-v_reg) : v_reg),
        .mag_e (mul_e[31] ? 32'(-mul_e) : mul_e),
        .done  (mdone),
        .prod  (mprod)
    );

    assign n_clip = (32'(req.power_order) > MAX_ORDER) ? 5'(MAX_ORDER) : req.power_order;
    assign mul_e  = (k_reg < 6'(n_reg) - i_reg) ? big_reg : sml_reg;
    assign swap   = vp_reg < vq_reg;
    assign dtrial = {rem_reg[32:0], binom_reg[33]} - 34'(i_reg);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        big_next   = big_reg;
        sml_next   = sml_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        v_next     = v_reg;
        binom_next = binom_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        rv_next    = 1'b0;
        res_next   = res_reg;
        mctl       = '0;
        mctl.neg   = v_reg[62] ^ mul_e[31];
        wr_en      = 1'b0;
        wr_addr    = i_reg[4:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = n_clip;
                    big_next   = req.eig_large;
                    sml_next   = req.eig_small;
                    i_next     = '0;
                    k_next     = '0;
                    v_next     = 63'sd1 <<< FRAC_BITS;
                    binom_next = 34'd1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (k_reg == 6'(n_reg))
                begin
                    wr_en = 1'b1;
                    if (i_reg == 6'(n_reg))
                    begin
                        p_next     = '0;
                        q_next     = 5'd1;
                        state_next = (n_reg == 5'd0) ? S_ERD : S_SRD;
                    end
                    else
                    begin
                        i_next     = i_reg + 6'd1;
                        k_next     = '0;
                        v_next     = 63'sd1 <<< FRAC_BITS;
                        binom_next = binom_reg * 34'(6'(n_reg) - i_reg);
                        rem_next   = '0;
                        dcnt_next  = '0;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    mctl.start = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (mdone)
                begin
                    v_next     = mprod;
                    k_next     = k_reg + 6'd1;
                    state_next = S_MUL;
                end
            end
            S_DIV:
            begin
                if (!dtrial[33])
                begin
                    rem_next   = dtrial;
                    binom_next = {binom_reg[32:0], 1'b1};
                end
                else
                begin
                    rem_next   = {rem_reg[32:0], binom_reg[33]};
                    binom_next = {binom_reg[32:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd33)
                begin
                    state_next = S_MUL;
                end
            end
            S_SRD:
            begin
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (q_reg == n_reg)
                begin
                    if (p_reg + 5'd1 == n_reg)
                    begin
                        p_next     = '0;
                        state_next = S_ERD;
                    end
                    else
                    begin
                        p_next     = p_reg + 5'd1;
                        q_next     = p_reg + 5'd2;
                        state_next = S_SRD;
                    end
                end
                else
                begin
                    q_next     = q_reg + 5'd1;
                    state_next = S_SRD;
                end
            end
            S_ERD:
            begin
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                rv_next                = 1'b1;
                res_next.eig_value     = vp_reg;
                res_next.multiplicity  = mp_reg;
                res_next.rank_index    = p_reg;
                res_next.last_pair     = (p_reg == n_reg);
                if (p_reg == n_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    p_next     = p_reg + 5'd1;
                    state_next = S_EOUT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The pair memories are written while building and swapping and are read
    // with registered data at the next pointers.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_addr] <= v_reg;
            mult_mem[wr_addr]  <= binom_reg[28:0];
        end
        else if (state_reg == S_SCMP && swap)
        begin
            value_mem[p_reg] <= vq_reg;
            mult_mem[p_reg]  <= mq_reg;
            value_mem[q_reg] <= vp_reg;
            mult_mem[q_reg]  <= mp_reg;
        end
        if (state_reg == S_SCMP && swap)
        begin
            vp_reg <= vq_reg;
            mp_reg <= mq_reg;
        end
        else if (state_reg == S_EOUT || state_reg == S_ERD)
        begin
            vp_reg <= value_mem[p_next];
            mp_reg <= mult_mem[p_next];
        end
        else
        begin
            vp_reg <= value_mem[p_next];
            mp_reg <= mult_mem[p_next];
        end
        vq_reg <= value_mem[q_next];
        mq_reg <= mult_mem[q_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        big_reg   <= big_next;
        sml_reg   <= sml_next;
        i_reg     <= i_next;
        k_reg     <= k_next;
        v_reg     <= v_next;
        binom_reg <= binom_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        res_reg   <= res_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = rv_reg;
    assign res       = res_reg;
endmodule
`default_nettype wire

[hdl/kes_checker.sv]
// Port checker for the Kronecker eigenvalue spectrum block and its bind.
`default_nettype none
`include "kronecker_eigen_spectrum_assert.svh"
module kes_port_checker
    import kes_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     res_valid,
    input wire kes_res_t res
);
    `KES_ASSERT_IMP(a_res_busy, clk, rst_n, res_valid && !res.last_pair, busy)
    `KES_ASSERT_NXT(a_rank_step, clk, rst_n, res_valid && !res.last_pair,
        res_valid && res.rank_index == $past(res.rank_index) + 5'd1)
    `KES_ASSERT_NXT(a_last_idle, clk, rst_n, res_valid && res.last_pair, !res_valid)
    `KES_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
endmodule

bind kronecker_eigen_spectrum kes_port_checker u_kes_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
);
`default_nettype wire
